>>> design/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types, codes and constants of the tachometer period autorange block.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int STAMP_W     = 16;
    localparam int PERIOD_W    = 32;
    localparam int COUNT_W     = 32;
    localparam int TPERIOD_W   = 17;
    localparam int TIMEOUT_W   = 16;
    localparam int CPM_W       = 34;
    localparam int SPEED_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 34;
    localparam int DIV_CNT_W   = $clog2(CPM_W + 1);

    // operation codes
    localparam logic [1:0] OP_OVERFLOW = 2'd0;
    localparam logic [1:0] OP_CAPTURE  = 2'd1;
    localparam logic [1:0] OP_REARM    = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_PERIOD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCKS_PER_MIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_THRESH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_THRESH   = 3'd4;

    // register reset values
    localparam logic [TPERIOD_W-1:0] RST_TIMER_PERIOD = 17'd50000;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT      = 16'd9600;
    localparam logic [CPM_W-1:0]     RST_CLOCKS_PER_MIN = 34'd5760000000;
    localparam logic [PERIOD_W-1:0]  RST_FAST_THRESH  = 32'd5000;
    localparam logic [PERIOD_W-1:0]  RST_SLOW_THRESH  = 32'd50000;

    localparam logic [1:0] PRESCALE_FAST = 2'd3;
    localparam logic [1:0] PRESCALE_SLOW = 2'd0;

    typedef struct packed {
        logic [1:0]         operation;
        logic [STAMP_W-1:0] capture_value;
        logic               capture_overrun;
    } t_in_word;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [SPEED_W-1:0]  speed_per_minute;
        logic [1:0]          prescale_code;
        logic                capture_enabled;
        logic                overrun_pending;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SPAN,
        S_RANGE,
        S_SPEED,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> design/tpa_mul.sv
// ----------------------------------------------------------------------------
// tpa_mul
// Bit-serial shift-add multiplier, overflow count times timer period, keeping
// the low period bits. One multiplier bit per cycle, stops when none are left.
// ----------------------------------------------------------------------------
module tpa_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tpa_pkg::COUNT_W-1:0]   i_mcand,
    input  logic [tpa_pkg::TPERIOD_W-1:0] i_mplier,
    output logic                          o_done,
    output logic [tpa_pkg::PERIOD_W-1:0]  o_product
);

    logic                          r_busy;
    logic                          n_busy;
    logic [tpa_pkg::PERIOD_W-1:0]  r_mcand;
    logic [tpa_pkg::PERIOD_W-1:0]  n_mcand;
    logic [tpa_pkg::TPERIOD_W-1:0] r_mplier;
    logic [tpa_pkg::TPERIOD_W-1:0] n_mplier;
    logic [tpa_pkg::PERIOD_W-1:0]  r_acc;
    logic [tpa_pkg::PERIOD_W-1:0]  n_acc;

    always_comb begin
        n_busy   = r_busy;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        if (i_start) begin
            n_busy   = 1'b1;
            n_mcand  = tpa_pkg::PERIOD_W'(i_mcand);
            n_mplier = i_mplier;
            n_acc    = '0;
        end else if (r_busy) begin
            if (r_mplier == '0) begin
                n_busy = 1'b0;
            end else begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[tpa_pkg::PERIOD_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[tpa_pkg::TPERIOD_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_done    = r_busy && (r_mplier == '0);
    assign o_product = r_acc;

endmodule

>>> design/tpa_div.sv
// ----------------------------------------------------------------------------
// tpa_div
// Restoring bit-serial divider for the speed figure: one quotient bit per
// cycle, quotient saturated to the speed width.
// ----------------------------------------------------------------------------
module tpa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tpa_pkg::CPM_W-1:0]    i_dividend,
    input  logic [tpa_pkg::PERIOD_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [tpa_pkg::SPEED_W-1:0]  o_quotient
);

    logic                          r_busy;
    logic                          n_busy;
    logic [tpa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [tpa_pkg::DIV_CNT_W-1:0] n_cnt;
    logic [tpa_pkg::PERIOD_W-1:0]  r_rem;
    logic [tpa_pkg::PERIOD_W-1:0]  n_rem;
    logic [tpa_pkg::CPM_W-1:0]     r_quo;
    logic [tpa_pkg::CPM_W-1:0]     n_quo;
    logic [tpa_pkg::PERIOD_W-1:0]  r_divisor;
    logic [tpa_pkg::PERIOD_W:0]    trial;
    logic [tpa_pkg::PERIOD_W:0]    diff;

    assign trial = {r_rem, r_quo[tpa_pkg::CPM_W-1]};
    assign diff  = trial - {1'b0, r_divisor};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = tpa_pkg::DIV_CNT_W'(tpa_pkg::CPM_W);
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                // dividend bits shift out the top while quotient bits enter below
                if (!diff[tpa_pkg::PERIOD_W]) begin
                    n_rem = diff[tpa_pkg::PERIOD_W-1:0];
                    n_quo = {r_quo[tpa_pkg::CPM_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[tpa_pkg::PERIOD_W-1:0];
                    n_quo = {r_quo[tpa_pkg::CPM_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_divisor <= i_divisor;
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = (r_quo[tpa_pkg::CPM_W-1:tpa_pkg::SPEED_W] != '0) ?
                        '1 : r_quo[tpa_pkg::SPEED_W-1:0];

endmodule

>>> design/tachometer_period_autorange_top.sv
// ----------------------------------------------------------------------------
// tachometer_period_autorange_top
// Tachometer period measurement with prescaler autorange and speed output.
// ----------------------------------------------------------------------------
// sequence: a second capture runs the serial multiply, which ends after the top
//   set bit of the timer period; the divide is skipped when the speed is zero
// pacing: a word is accepted only in idle, once the previous result is in the
//   output register; the 34-step serial divider sets the pace
// reset: synchronous active low, registers return to their defaults, capture
//   armed, no measurement held
module tachometer_period_autorange_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tpa_pkg::t_in_word               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tpa_pkg::t_out_word              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tpa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tpa_pkg::t_state r_state;
    tpa_pkg::t_state n_state;

    logic [tpa_pkg::TPERIOD_W-1:0] r_timer_period;
    logic [tpa_pkg::TPERIOD_W-1:0] n_timer_period;
    logic [tpa_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [tpa_pkg::TIMEOUT_W-1:0] n_timeout;
    logic [tpa_pkg::CPM_W-1:0]     r_cpm;
    logic [tpa_pkg::CPM_W-1:0]     n_cpm;
    logic [tpa_pkg::PERIOD_W-1:0]  r_fast;
    logic [tpa_pkg::PERIOD_W-1:0]  n_fast;
    logic [tpa_pkg::PERIOD_W-1:0]  r_slow;
    logic [tpa_pkg::PERIOD_W-1:0]  n_slow;

    logic                         r_first;
    logic                         n_first;
    logic [tpa_pkg::STAMP_W-1:0]  r_stamp;
    logic [tpa_pkg::STAMP_W-1:0]  n_stamp;
    logic [tpa_pkg::COUNT_W-1:0]  r_count;
    logic [tpa_pkg::COUNT_W-1:0]  n_count;
    logic [tpa_pkg::PERIOD_W-1:0] r_period;
    logic [tpa_pkg::PERIOD_W-1:0] n_period;
    logic [1:0]                   r_prescale;
    logic [1:0]                   n_prescale;
    logic                         r_armed;
    logic                         n_armed;
    logic                         r_overrun;
    logic                         n_overrun;

    logic [tpa_pkg::STAMP_W-1:0]  r_cap_value;
    logic [tpa_pkg::STAMP_W-1:0]  n_cap_value;
    logic                         r_cap_overrun;
    logic                         n_cap_overrun;
    logic [tpa_pkg::SPEED_W-1:0]  r_speed;
    logic [tpa_pkg::SPEED_W-1:0]  n_speed;

    logic                         r_out_valid;
    logic                         n_out_valid;
    tpa_pkg::t_out_word           r_out;
    tpa_pkg::t_out_word           n_out;

    logic                         in_fire;
    logic                         mul_start;
    logic                         mul_done;
    logic [tpa_pkg::PERIOD_W-1:0] mul_product;
    logic                         div_start;
    logic                         div_done;
    logic [tpa_pkg::SPEED_W-1:0]  div_quotient;
    logic [tpa_pkg::COUNT_W-1:0]  count_inc;
    logic [tpa_pkg::PERIOD_W-1:0] span;

    assign o_in_ready = (r_state == tpa_pkg::S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;
    assign span      = tpa_pkg::PERIOD_W'(r_cap_value) + mul_product
                       - tpa_pkg::PERIOD_W'(r_stamp);

    tpa_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (r_count),
        .i_mplier  (r_timer_period),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    tpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cpm),
        .i_divisor  (r_period),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // configuration writes
    always_comb begin
        n_timer_period = r_timer_period;
        n_timeout      = r_timeout;
        n_cpm          = r_cpm;
        n_fast         = r_fast;
        n_slow         = r_slow;
        if (i_cfg_we) begin
            case (i_cfg_index)
                tpa_pkg::CFG_TIMER_PERIOD: begin
                    n_timer_period = i_cfg_data[tpa_pkg::TPERIOD_W-1:0];
                end
                tpa_pkg::CFG_TIMEOUT: begin
                    n_timeout = i_cfg_data[tpa_pkg::TIMEOUT_W-1:0];
                end
                tpa_pkg::CFG_CLOCKS_PER_MIN: begin
                    n_cpm = i_cfg_data[tpa_pkg::CPM_W-1:0];
                end
                tpa_pkg::CFG_FAST_THRESH: begin
                    n_fast = i_cfg_data[tpa_pkg::PERIOD_W-1:0];
                end
                tpa_pkg::CFG_SLOW_THRESH: begin
                    n_slow = i_cfg_data[tpa_pkg::PERIOD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer: next state and datapath updates
    always_comb begin
        n_state       = r_state;
        n_first       = r_first;
        n_stamp       = r_stamp;
        n_count       = r_count;
        n_period      = r_period;
        n_prescale    = r_prescale;
        n_armed       = r_armed;
        n_overrun     = r_overrun;
        n_cap_value   = r_cap_value;
        n_cap_overrun = r_cap_overrun;
        n_speed       = r_speed;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        case (r_state)
            tpa_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = tpa_pkg::S_SPEED;
                    case (i_in_data.operation)
                        tpa_pkg::OP_OVERFLOW: begin
                            n_count = count_inc;
                            if (count_inc > tpa_pkg::COUNT_W'(r_timeout)) begin
                                n_period   = '0;
                                n_prescale = tpa_pkg::PRESCALE_SLOW;
                            end
                        end
                        tpa_pkg::OP_CAPTURE: begin
                            if (r_armed) begin
                                if (!r_first) begin
                                    n_count = '0;
                                    n_first = 1'b1;
                                    n_stamp = i_in_data.capture_value;
                                end else begin
                                    n_cap_value   = i_in_data.capture_value;
                                    n_cap_overrun = i_in_data.capture_overrun;
                                    mul_start     = 1'b1;
                                    n_state       = tpa_pkg::S_MUL;
                                end
                            end
                        end
                        tpa_pkg::OP_REARM: begin
                            n_armed   = 1'b1;
                            n_overrun = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tpa_pkg::S_MUL: begin
                if (mul_done) begin
                    n_state = tpa_pkg::S_SPAN;
                end
            end
            tpa_pkg::S_SPAN: begin
                n_period  = span >> r_prescale;
                n_overrun = r_overrun | r_cap_overrun;
                n_first   = 1'b0;
                n_armed   = 1'b0;
                n_state   = tpa_pkg::S_RANGE;
            end
            tpa_pkg::S_RANGE: begin
                // slow test wins when both thresholds are crossed
                if (r_period > r_slow) begin
                    n_prescale = tpa_pkg::PRESCALE_SLOW;
                end else if (r_period < r_fast) begin
                    n_prescale = tpa_pkg::PRESCALE_FAST;
                end
                n_state = tpa_pkg::S_SPEED;
            end
            tpa_pkg::S_SPEED: begin
                if ((r_period == '0) || r_overrun) begin
                    n_speed = '0;
                    n_state = tpa_pkg::S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = tpa_pkg::S_DIV;
                end
            end
            tpa_pkg::S_DIV: begin
                if (div_done) begin
                    n_speed = div_quotient;
                    n_state = tpa_pkg::S_DONE;
                end
            end
            tpa_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out.period_ticks     = r_period;
                    n_out.speed_per_minute = r_speed;
                    n_out.prescale_code    = r_prescale;
                    n_out.capture_enabled  = r_armed;
                    n_out.overrun_pending  = r_overrun;
                    n_state                = tpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_period <= tpa_pkg::RST_TIMER_PERIOD;
            r_timeout      <= tpa_pkg::RST_TIMEOUT;
            r_cpm          <= tpa_pkg::RST_CLOCKS_PER_MIN;
            r_fast         <= tpa_pkg::RST_FAST_THRESH;
            r_slow         <= tpa_pkg::RST_SLOW_THRESH;
            r_first        <= 1'b0;
            r_stamp        <= '0;
            r_count        <= '0;
            r_period       <= '0;
            r_prescale     <= tpa_pkg::PRESCALE_SLOW;
            r_armed        <= 1'b1;
            r_overrun      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_timer_period <= n_timer_period;
            r_timeout      <= n_timeout;
            r_cpm          <= n_cpm;
            r_fast         <= n_fast;
            r_slow         <= n_slow;
            r_first        <= n_first;
            r_stamp        <= n_stamp;
            r_count        <= n_count;
            r_period       <= n_period;
            r_prescale     <= n_prescale;
            r_armed        <= n_armed;
            r_overrun      <= n_overrun;
            r_out_valid    <= n_out_valid;
        end
        r_cap_value   <= n_cap_value;
        r_cap_overrun <= n_cap_overrun;
        r_speed       <= n_speed;
        r_out         <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_arm_clear_on_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_armed) |-> $past(r_state) == tpa_pkg::S_SPAN)
        else $error("capture disarmed outside a completed measurement");

    a_speed_needs_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.speed_per_minute != '0)) |->
        ((o_out_data.period_ticks != '0) && !o_out_data.overrun_pending))
        else $error("speed reported without a valid period");

    a_mul_only_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == tpa_pkg::S_MUL))
        else $error("multiplier finished outside its state");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == tpa_pkg::S_DIV))
        else $error("divider finished outside its state");

endmodule

>>> verif/tachometer_period_autorange_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tachometer_period_autorange testbench
// Drives overflow, capture and rearm words through the valid/ready input and
// checks every result word against a cycle-free predictor of the tachometer
// or a scripted expected word. A short scripted sequence comes first. Random
// measurement sequences follow under several register settings and idle
// patterns, including a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam tpa_pkg::t_out_word ARMED_EMPTY =
        '{32'd0, 32'd0, tpa_pkg::PRESCALE_SLOW, 1'b1, 1'b0};

    typedef struct {
        tpa_pkg::t_in_word  word;
        bit                 typed;
        tpa_pkg::t_out_word result;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    tpa_pkg::t_in_word in_data = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [tpa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic o_in_ready;
    logic o_out_valid;
    tpa_pkg::t_out_word o_out_data;

    tachometer_period_autorange_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // predictor copy of registers and measurement state
    logic [tpa_pkg::TPERIOD_W-1:0] tp_reg;
    logic [tpa_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [tpa_pkg::CPM_W-1:0]     cpm_reg;
    logic [tpa_pkg::PERIOD_W-1:0]  fast_reg;
    logic [tpa_pkg::PERIOD_W-1:0]  slow_reg;
    logic                          have_start;
    logic [tpa_pkg::STAMP_W-1:0]   stamp;
    logic [tpa_pkg::COUNT_W-1:0]   ovf_count;
    logic [tpa_pkg::PERIOD_W-1:0]  period_now;
    logic [1:0]                    code_now;
    logic                          armed_now;
    logic                          overrun_now;

    tpa_pkg::t_out_word expected_words[$];
    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;

    task automatic clear_tach_state();
        tp_reg      = tpa_pkg::RST_TIMER_PERIOD;
        timeout_reg = tpa_pkg::RST_TIMEOUT;
        cpm_reg     = tpa_pkg::RST_CLOCKS_PER_MIN;
        fast_reg    = tpa_pkg::RST_FAST_THRESH;
        slow_reg    = tpa_pkg::RST_SLOW_THRESH;
        have_start  = 1'b0;
        stamp       = '0;
        ovf_count   = '0;
        period_now  = '0;
        code_now    = tpa_pkg::PRESCALE_SLOW;
        armed_now   = 1'b1;
        overrun_now = 1'b0;
    endtask

    function automatic tpa_pkg::t_out_word tach_predict(input tpa_pkg::t_in_word w);
        logic [63:0] span;
        logic [63:0] quot;
        tpa_pkg::t_out_word r;
        case (w.operation)
            tpa_pkg::OP_OVERFLOW: begin
                if (ovf_count != '1)
                    ovf_count = ovf_count + 1'b1;
                if (ovf_count > {16'd0, timeout_reg}) begin
                    period_now = '0;
                    code_now   = tpa_pkg::PRESCALE_SLOW;
                end
            end
            tpa_pkg::OP_CAPTURE: begin
                if (armed_now && !have_start) begin
                    ovf_count  = '0;
                    have_start = 1'b1;
                    stamp      = w.capture_value;
                end else if (armed_now) begin
                    armed_now = 1'b0;
                    span = {48'd0, w.capture_value} + {32'd0, ovf_count} * {47'd0, tp_reg}
                         - {48'd0, stamp};
                    period_now = span[31:0] >> code_now;
                    if (w.capture_overrun)
                        overrun_now = 1'b1;
                    if (period_now < fast_reg)
                        code_now = tpa_pkg::PRESCALE_FAST;
                    if (period_now > slow_reg)
                        code_now = tpa_pkg::PRESCALE_SLOW;
                    have_start = 1'b0;
                end
            end
            tpa_pkg::OP_REARM: begin
                armed_now   = 1'b1;
                overrun_now = 1'b0;
            end
            default: begin
            end
        endcase
        r.period_ticks = period_now;
        if (period_now == '0 || overrun_now) begin
            r.speed_per_minute = '0;
        end else begin
            quot = {30'd0, cpm_reg} / {32'd0, period_now};
            r.speed_per_minute = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
        end
        r.prescale_code   = code_now;
        r.capture_enabled = armed_now;
        r.overrun_pending = overrun_now;
        return r;
    endfunction

    task automatic load_registers(input logic [tpa_pkg::CFG_DATA_W-1:0] tp,
                                  input logic [tpa_pkg::CFG_DATA_W-1:0] tmo,
                                  input logic [tpa_pkg::CFG_DATA_W-1:0] cpm,
                                  input logic [tpa_pkg::CFG_DATA_W-1:0] fast,
                                  input logic [tpa_pkg::CFG_DATA_W-1:0] slow);
        logic [tpa_pkg::CFG_INDEX_W-1:0] idx_list[5];
        logic [tpa_pkg::CFG_DATA_W-1:0] val_list[5];
        idx_list = '{tpa_pkg::CFG_TIMER_PERIOD, tpa_pkg::CFG_TIMEOUT,
                     tpa_pkg::CFG_CLOCKS_PER_MIN, tpa_pkg::CFG_FAST_THRESH,
                     tpa_pkg::CFG_SLOW_THRESH};
        val_list = '{tp, tmo, cpm, fast, slow};
        for (int k = 0; k < 5; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= val_list[k];
            case (idx_list[k])
                tpa_pkg::CFG_TIMER_PERIOD:
                    tp_reg      = val_list[k][tpa_pkg::TPERIOD_W-1:0];
                tpa_pkg::CFG_TIMEOUT:
                    timeout_reg = val_list[k][tpa_pkg::TIMEOUT_W-1:0];
                tpa_pkg::CFG_CLOCKS_PER_MIN:
                    cpm_reg     = val_list[k][tpa_pkg::CPM_W-1:0];
                tpa_pkg::CFG_FAST_THRESH:
                    fast_reg    = val_list[k][tpa_pkg::PERIOD_W-1:0];
                tpa_pkg::CFG_SLOW_THRESH:
                    slow_reg    = val_list[k][tpa_pkg::PERIOD_W-1:0];
                default: begin
                end
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(input tpa_pkg::t_in_word w, input bit typed,
                             input tpa_pkg::t_out_word known);
        tpa_pkg::t_out_word pred;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        pred = tach_predict(w);
        expected_words.push_back(typed ? known : pred);
        do @(posedge clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // mostly rearm, capture, a few ticks, capture; the rest is loose noise
    task automatic run_traffic(input int n_words);
        int sent;
        int ticks;
        logic [tpa_pkg::STAMP_W-1:0] start_value;
        logic [tpa_pkg::STAMP_W-1:0] end_value;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 75) begin
                start_value = 16'($urandom);
                send_word(tpa_pkg::t_in_word'{tpa_pkg::OP_REARM, 16'($urandom), 1'($urandom)},
                          1'b0, '0);
                send_word(tpa_pkg::t_in_word'{tpa_pkg::OP_CAPTURE, start_value, 1'($urandom)},
                          1'b0, '0);
                ticks = ($urandom_range(99) < 85) ? $urandom_range(0, 3) : $urandom_range(0, 12);
                for (int t = 0; t < ticks; t++)
                    send_word(tpa_pkg::t_in_word'{tpa_pkg::OP_OVERFLOW, 16'($urandom),
                                                  1'($urandom)}, 1'b0, '0);
                if ($urandom_range(1))
                    end_value = start_value + 16'($urandom_range(0, 8000));
                else
                    end_value = 16'($urandom);
                send_word(tpa_pkg::t_in_word'{tpa_pkg::OP_CAPTURE, end_value, 1'($urandom)},
                          1'b0, '0);
                sent += 3 + ticks;
            end else begin
                send_word(tpa_pkg::t_in_word'{2'($urandom), 16'($urandom), 1'($urandom)},
                          1'b0, '0);
                sent++;
            end
        end
    endtask

    function automatic t_row row(input logic [1:0] op,
                                 input logic [tpa_pkg::STAMP_W-1:0] val,
                                 input logic ovr, input bit typed = 1'b0,
                                 input tpa_pkg::t_out_word res = '0);
        t_row r;
        r.word   = '{op, val, ovr};
        r.typed  = typed;
        r.result = res;
        return r;
    endfunction

    // output side: checks each accepted word and paces ready
    initial begin : result_checker
        int hold_left;
        int holds_seen;
        tpa_pkg::t_out_word exp_word;
        hold_left = 0;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid === 1'b1 && out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", o_out_data);
                    mismatch_count++;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (o_out_data.period_ticks !== exp_word.period_ticks) begin
                        $error("period_ticks: expected %0d, actual %0d",
                               exp_word.period_ticks, o_out_data.period_ticks);
                        mismatch_count++;
                    end
                    if (o_out_data.speed_per_minute !== exp_word.speed_per_minute) begin
                        $error("speed_per_minute: expected %0d, actual %0d",
                               exp_word.speed_per_minute, o_out_data.speed_per_minute);
                        mismatch_count++;
                    end
                    if (o_out_data.prescale_code !== exp_word.prescale_code) begin
                        $error("prescale_code: expected %0d, actual %0d",
                               exp_word.prescale_code, o_out_data.prescale_code);
                        mismatch_count++;
                    end
                    if (o_out_data.capture_enabled !== exp_word.capture_enabled) begin
                        $error("capture_enabled: expected %0d, actual %0d",
                               exp_word.capture_enabled, o_out_data.capture_enabled);
                        mismatch_count++;
                    end
                    if (o_out_data.overrun_pending !== exp_word.overrun_pending) begin
                        $error("overrun_pending: expected %0d, actual %0d",
                               exp_word.overrun_pending, o_out_data.overrun_pending);
                        mismatch_count++;
                    end
                end
            end
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin : stimulus
        t_row script[$];
        clear_tach_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers still active
        script.push_back(row(tpa_pkg::OP_OVERFLOW, 16'h0000, 1'b0, 1'b1, ARMED_EMPTY));
        script.push_back(row(OP_UNUSED,            16'hFFFF, 1'b1, 1'b1, ARMED_EMPTY));
        script.push_back(row(tpa_pkg::OP_REARM,    16'h0000, 1'b1, 1'b1, ARMED_EMPTY));
        // first capture drops the overrun bit
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'hFFFF, 1'b1, 1'b1, ARMED_EMPTY));
        script.push_back(row(tpa_pkg::OP_OVERFLOW, 16'h5A5A, 1'b0, 1'b1, ARMED_EMPTY));
        // span wraps below zero
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'h0000, 1'b0));
        // capture while disabled is ignored
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'h04D2, 1'b1));
        script.push_back(row(tpa_pkg::OP_OVERFLOW, 16'hA5A5, 1'b1));
        script.push_back(row(tpa_pkg::OP_REARM,    16'h0000, 1'b0));
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'd100,  1'b0));
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'd1100, 1'b0, 1'b1,
                             '{32'd1000, 32'd5760000, tpa_pkg::PRESCALE_FAST, 1'b0, 1'b0}));
        script.push_back(row(tpa_pkg::OP_REARM,    16'hFFFF, 1'b0));
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'h0000, 1'b0));
        script.push_back(row(tpa_pkg::OP_OVERFLOW, 16'h0000, 1'b0));
        // shifted by the fast code, overrun forces zero speed
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'hFFFF, 1'b1));
        script.push_back(row(tpa_pkg::OP_OVERFLOW, 16'h0000, 1'b0));
        script.push_back(row(tpa_pkg::OP_REARM,    16'h0000, 1'b0));
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'd7,    1'b0));
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'd7,    1'b0, 1'b1,
                             '{32'd0, 32'd0, tpa_pkg::PRESCALE_FAST, 1'b0, 1'b0}));
        script.push_back(row(tpa_pkg::OP_REARM,    16'h0000, 1'b0));
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'h0000, 1'b0));
        script.push_back(row(tpa_pkg::OP_CAPTURE,  16'h0001, 1'b1, 1'b1,
                             '{32'd0, 32'd0, tpa_pkg::PRESCALE_FAST, 1'b0, 1'b1}));
        script.push_back(row(tpa_pkg::OP_REARM,    16'h0000, 1'b1, 1'b1,
                             '{32'd0, 32'd0, tpa_pkg::PRESCALE_FAST, 1'b1, 1'b0}));
        script.push_back(row(OP_UNUSED,            16'h0000, 1'b0, 1'b1,
                             '{32'd0, 32'd0, tpa_pkg::PRESCALE_FAST, 1'b1, 1'b0}));
        foreach (script[i])
            send_word(script[i].word, script[i].typed, script[i].result);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            case (p)
                0: load_registers(34'd50000, 34'd9600, 34'd5760000000, 34'd5000, 34'd50000);
                1: load_registers(34'd1, 34'd0, 34'd1, 34'd0, 34'd0);
                2: load_registers(34'd65536, 34'd65535, 34'h3_FFFF_FFFF,
                                  34'hFFFF_FFFF, 34'hFFFF_FFFF);
                3: load_registers(34'd0, 34'd3, 34'd0, 34'd3000, 34'd60000);
                4: load_registers(34'd131071, 34'd2, 34'h3_FFFF_FFFF, 34'd40000, 34'd100);
                // raw data wider than the registers
                5: load_registers({2'($urandom), 32'($urandom)}, {2'($urandom), 32'($urandom)},
                                  {2'($urandom), 32'($urandom)}, {2'($urandom), 32'($urandom)},
                                  {2'($urandom), 32'($urandom)});
                default: load_registers(34'($urandom_range(0, 70000)), 34'($urandom_range(0, 20)),
                                        {2'($urandom), 32'($urandom)},
                                        34'($urandom_range(0, 100000)),
                                        34'($urandom_range(0, 300000)));
            endcase
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 57;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 57;
                end
                default: begin
                    sender_idle_pct = 30;
                    receiver_stall_pct = 30;
                end
            endcase
            // output held off while the input keeps offering words
            if (p == 2)
                hold_requests++;
            run_traffic(90);
            if (p == 5)
                wait_drained();
            run_traffic(90);
        end

        in_valid <= 1'b0;
        for (int c = 0; c < 20000 && expected_words.size() != 0; c++)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> files.f
design/tpa_pkg.sv
design/tpa_mul.sv
design/tpa_div.sv
design/tachometer_period_autorange_top.sv
verif/tachometer_period_autorange_tb.sv
